// ===== design/rdc_pkg.sv =====
package rdc_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned IDX_W      = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RadixMin = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RadixMax = RADIX_W'(16);
  localparam logic [CHAR_W-1:0]  CharZero = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CharA    = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0]  CharNone = '0;
  localparam logic [DIGIT_W-1:0] DigitTen = DIGIT_W'(10);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StRead,
    StSend
  } state_e;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DigitTen) begin
      c = CharZero + CHAR_W'(d);
    end else begin
      c = CharA + CHAR_W'(d - DigitTen);
    end
    return c;
  endfunction

endpackage

// ===== design/radix_digit_converter.sv =====
// Converts a non-negative integer to upper-case ASCII digits in a radix from
// 2 to 16, most significant digit first, last set on the final digit. Each
// digit comes from a bit-serial divider and is written to the digit store;
// the digits are then read back from the store one at a time and sent, and
// an item keeps busy high until its last digit is sent. A zero value or a
// radix outside 2..16 gives one result the cycle after start and leaves
// busy low. Results come one per valid_o pulse and cannot be held off: the
// receiver must take every item on the cycle it is shown.
module radix_digit_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rdc_pkg::in_item_t   in_i,
  output logic                valid_o,
  output rdc_pkg::out_item_t  out_o
);

  rdc_pkg::state_e                state_q, state_d;
  logic [rdc_pkg::RADIX_W-1:0]    radix_q;
  logic [rdc_pkg::IDX_W-1:0]      wr_idx_q, wr_idx_d;
  logic [rdc_pkg::IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                           out_valid_q, out_valid_d;
  rdc_pkg::out_item_t             out_q, out_d;

  logic                           accept;
  logic                           bad;
  logic                           div_start;
  logic [rdc_pkg::VALUE_BITS-1:0] dividend;
  logic [rdc_pkg::RADIX_W-1:0]    divisor;
  logic                           div_done;
  logic [rdc_pkg::VALUE_BITS-1:0] quotient;
  logic [rdc_pkg::DIGIT_W-1:0]    remainder;
  logic                           st_we;
  logic [rdc_pkg::DIGIT_W-1:0]    st_rdata;
  logic                           div_end;

  assign accept  = start && (state_q == rdc_pkg::StIdle);
  assign bad     = (in_i.radix < rdc_pkg::RadixMin) || (in_i.radix > rdc_pkg::RadixMax);
  assign div_end = (quotient == '0) ||
                   (wr_idx_q == rdc_pkg::IDX_W'(rdc_pkg::VALUE_BITS - 1));

  rdc_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  rdc_digit_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (wr_idx_q),
    .wdata_i (remainder),
    .raddr_i (rd_idx_q),
    .rdata_o (st_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdc_pkg::StIdle: begin
        if (accept && !bad && (in_i.value != '0)) begin
          state_d = rdc_pkg::StDivide;
        end
      end
      rdc_pkg::StDivide: begin
        if (div_done && div_end) begin
          state_d = rdc_pkg::StRead;
        end
      end
      rdc_pkg::StRead: begin
        state_d = rdc_pkg::StSend;
      end
      rdc_pkg::StSend: begin
        state_d = (rd_idx_q == '0) ? rdc_pkg::StIdle : rdc_pkg::StRead;
      end
      default: begin
        state_d = rdc_pkg::StIdle;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    div_start   = 1'b0;
    dividend    = in_i.value;
    divisor     = in_i.radix;
    st_we       = 1'b0;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    unique case (state_q)
      rdc_pkg::StIdle: begin
        wr_idx_d = '0;
        if (accept) begin
          if (bad) begin
            out_valid_d      = 1'b1;
            out_d.digit_char = rdc_pkg::CharNone;
            out_d.last       = 1'b1;
            out_d.bad_radix  = 1'b1;
          end else if (in_i.value == '0) begin
            out_valid_d      = 1'b1;
            out_d.digit_char = rdc_pkg::CharZero;
            out_d.last       = 1'b1;
            out_d.bad_radix  = 1'b0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      rdc_pkg::StDivide: begin
        dividend = quotient;
        divisor  = radix_q;
        if (div_done) begin
          st_we = 1'b1;
          if (div_end) begin
            rd_idx_d = wr_idx_q;
          end else begin
            div_start = 1'b1;
            wr_idx_d  = wr_idx_q + 1'b1;
          end
        end
      end
      rdc_pkg::StRead: begin
      end
      rdc_pkg::StSend: begin
        out_valid_d      = 1'b1;
        out_d.digit_char = rdc_pkg::to_ascii(st_rdata);
        out_d.last       = (rd_idx_q == '0);
        out_d.bad_radix  = 1'b0;
        if (rd_idx_q != '0) begin
          rd_idx_d = rd_idx_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdc_pkg::StIdle;
      out_valid_q <= 1'b0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      radix_q <= in_i.radix;
    end
  end

  assign busy    = (state_q != rdc_pkg::StIdle);
  assign valid_o = out_valid_q;
  assign out_o   = out_q;

endmodule

// ===== design/rdc_divider.sv =====
module rdc_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rdc_pkg::VALUE_BITS-1:0]      dividend_i,
  input  logic [rdc_pkg::RADIX_W-1:0]         divisor_i,
  output logic                                done_o,
  output logic [rdc_pkg::VALUE_BITS-1:0]      quotient_o,
  output logic [rdc_pkg::DIGIT_W-1:0]         remainder_o
);

  logic [rdc_pkg::VALUE_BITS-1:0] quo_q;
  logic [rdc_pkg::RADIX_W-1:0]    rem_q;
  logic [rdc_pkg::RADIX_W-1:0]    div_q;
  logic [rdc_pkg::CNT_W-1:0]      cnt_q;
  logic                           run_q;
  logic                           done_q;

  logic [rdc_pkg::RADIX_W-1:0]    rem_shift;
  logic                           q_bit;
  logic [rdc_pkg::RADIX_W-1:0]    rem_d;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_shift = {rem_q[rdc_pkg::RADIX_W-2:0], quo_q[rdc_pkg::VALUE_BITS-1]};
    q_bit     = (rem_shift >= div_q);
    rem_d     = q_bit ? (rem_shift - div_q) : rem_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
      cnt_q <= rdc_pkg::CNT_W'(rdc_pkg::VALUE_BITS - 1);
    end else if (run_q) begin
      quo_q <= {quo_q[rdc_pkg::VALUE_BITS-2:0], q_bit};
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[rdc_pkg::DIGIT_W-1:0];

endmodule

// ===== design/rdc_digit_store.sv =====
module rdc_digit_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [rdc_pkg::IDX_W-1:0]      waddr_i,
  input  logic [rdc_pkg::DIGIT_W-1:0]    wdata_i,
  input  logic [rdc_pkg::IDX_W-1:0]      raddr_i,
  output logic [rdc_pkg::DIGIT_W-1:0]    rdata_o
);

  logic [rdc_pkg::DIGIT_W-1:0] mem_q [rdc_pkg::VALUE_BITS];
  logic [rdc_pkg::DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/rdc_checker.sv =====
module rdc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  rdc_pkg::in_item_t  conv_req_i,
  input  logic               digit_valid_i,
  input  rdc_pkg::out_item_t digit_out_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 digits_seen_o
);

  localparam string HexChars = "0123456789ABCDEF";

  rdc_pkg::out_item_t expected_digits[$];

  function automatic void predict_conversion(input rdc_pkg::in_item_t req);
    rdc_pkg::out_item_t                    r;
    int unsigned                           base;
    int                                    n;
    logic [rdc_pkg::VALUE_BITS-1:0]        quotient;
    logic [rdc_pkg::DIGIT_W-1:0]           rem_mem [rdc_pkg::VALUE_BITS];
    base = req.radix;
    if (req.radix < rdc_pkg::RadixMin || req.radix > rdc_pkg::RadixMax) begin
      r.digit_char = rdc_pkg::CharNone;
      r.last       = 1'b1;
      r.bad_radix  = 1'b1;
      expected_digits.push_back(r);
      return;
    end
    if (req.value == '0) begin
      r.digit_char = rdc_pkg::CharZero;
      r.last       = 1'b1;
      r.bad_radix  = 1'b0;
      expected_digits.push_back(r);
      return;
    end
    quotient = req.value;
    n = 0;
    while (quotient != '0 && n < rdc_pkg::VALUE_BITS) begin
      rem_mem[n] = rdc_pkg::DIGIT_W'(quotient % base);
      quotient   = rdc_pkg::VALUE_BITS'(quotient / base);
      n++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      r.digit_char = rdc_pkg::CHAR_W'(HexChars[rem_mem[i]]);
      r.last       = (i == 0);
      r.bad_radix  = 1'b0;
      expected_digits.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin
    rdc_pkg::out_item_t exp_item;
    int                 n_err;
    n_err = 0;
    if (rst_ni) begin
      if (digit_valid_i) begin
        digits_seen_o <= digits_seen_o + 1;
        if (expected_digits.size() == 0) begin
          $error("unexpected result: digit_char %0h last %0b bad_radix %0b",
                 digit_out_i.digit_char, digit_out_i.last, digit_out_i.bad_radix);
          n_err++;
        end else begin
          exp_item = expected_digits.pop_front();
          if (digit_out_i.digit_char !== exp_item.digit_char) begin
            $error("digit_char: expected %0h, got %0h",
                   exp_item.digit_char, digit_out_i.digit_char);
            n_err++;
          end
          if (digit_out_i.last !== exp_item.last) begin
            $error("last: expected %0b, got %0b", exp_item.last, digit_out_i.last);
            n_err++;
          end
          if (digit_out_i.bad_radix !== exp_item.bad_radix) begin
            $error("bad_radix: expected %0b, got %0b",
                   exp_item.bad_radix, digit_out_i.bad_radix);
            n_err++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_conversion(conv_req_i);
      end
      errors_o <= errors_o + n_err;
    end
    pending_o <= expected_digits.size();
  end

endmodule

// ===== tb/radix_digit_converter_tb.sv =====
module radix_digit_converter_tb;

  localparam int PhaseItems = 86;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  rdc_pkg::in_item_t  conv_req = '0;
  logic               digit_valid;
  rdc_pkg::out_item_t digit_out;
  int                 errors;
  int                 pending;
  int                 digits_seen;
  int                 n_items = 0;
  int                 n_bad = 0;
  int                 n_zero = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  radix_digit_converter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (conv_req),
    .valid_o (digit_valid),
    .out_o   (digit_out)
  );

  rdc_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .conv_req_i    (conv_req),
    .digit_valid_i (digit_valid),
    .digit_out_i   (digit_out),
    .errors_o      (errors),
    .pending_o     (pending),
    .digits_seen_o (digits_seen)
  );

  task automatic send_conv(input rdc_pkg::in_item_t req, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start    <= 1'b1;
    conv_req <= req;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
    if (req.radix < rdc_pkg::RadixMin || req.radix > rdc_pkg::RadixMax) n_bad++;
    else if (req.value == '0) n_zero++;
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rdc_pkg::in_item_t              directed[$];
    rdc_pkg::in_item_t              req;
    int unsigned                    idle_pct[3];
    int unsigned                    pick;
    int unsigned                    width;
    logic [rdc_pkg::VALUE_BITS-1:0] mask;

    idle_pct = '{17, 53, 0};
    directed.push_back({31'd0, 5'd2});
    directed.push_back({31'd0, 5'd16});
    directed.push_back({31'h7FFFFFFF, 5'd2});
    directed.push_back({31'h7FFFFFFF, 5'd16});
    directed.push_back({31'h7FFFFFFF, 5'd3});
    directed.push_back({31'h7FFFFFFF, 5'd10});
    directed.push_back({31'h7EDCBA98, 5'd16});
    directed.push_back({31'h10325476, 5'd16});
    directed.push_back({31'd1, 5'd2});
    directed.push_back({31'd15, 5'd16});
    directed.push_back({31'd16, 5'd16});
    directed.push_back({31'd255, 5'd15});
    directed.push_back({31'd4, 5'd5});
    directed.push_back({31'h40000000, 5'd2});
    directed.push_back({31'h40000000, 5'd4});
    directed.push_back({31'd12345, 5'd0});
    directed.push_back({31'd0, 5'd0});
    directed.push_back({31'h7FFFFFFF, 5'd1});
    directed.push_back({31'd77, 5'd17});
    directed.push_back({31'h7FFFFFFF, 5'd31});
    directed.push_back({31'd1, 5'd16});

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_conv(directed[i], idle_pct[0]);

    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < PhaseItems; k++) begin
        pick  = $urandom_range(99);
        width = $urandom_range(1, rdc_pkg::VALUE_BITS);
        mask  = (rdc_pkg::VALUE_BITS'(1) << width) - rdc_pkg::VALUE_BITS'(1);
        req.value = rdc_pkg::VALUE_BITS'($urandom) & mask;
        if (pick < 8) begin
          req.radix = ($urandom_range(1) == 0) ? rdc_pkg::RADIX_W'($urandom_range(1))
                                               : rdc_pkg::RADIX_W'($urandom_range(17, 31));
        end else begin
          req.radix = rdc_pkg::RADIX_W'($urandom_range(2, 16));
          if (pick < 16) req.value = '0;
        end
        send_conv(req, idle_pct[phase]);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);

    $display("Converted %0d items, %0d with an out-of-range radix and %0d with value zero",
             n_items, n_bad, n_zero);
    $display("Checked %0d digit results under three levels of start idling", digits_seen);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rdc_pkg.sv
design/rdc_divider.sv
design/rdc_digit_store.sv
design/radix_digit_converter.sv
tb/rdc_checker.sv
tb/radix_digit_converter_tb.sv
